// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the visited-map filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled in reset
`define ASSERT_IMPL_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset
`define ASSERT_IMPL_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPL_NOW(lbl, clk, rst, ante, cons, msg)
`define ASSERT_IMPL_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/vbd_pkg.sv
// Package with types, codes and constants of the visited-map filter.
`default_nettype none

package vbd_pkg;

   // Field widths
   localparam int VX_W     = 23;
   localparam int WORD_W   = 16;
   localparam int BIT_W    = 4;
   localparam int WIDX_W   = VX_W - BIT_W;
   localparam int CH_W     = 2;
   localparam int CH_LO    = 13;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // Default map geometry
   localparam int BANK_DEPTH_DEF = 32768;
   localparam int BANKS_DEF      = 16;

   // Fixed-point shift of the reciprocal used for the word-index wrap
   localparam int RSHIFT = 20;

   // Request codes
   localparam logic REQ_START  = 1'b0;
   localparam logic REQ_VERTEX = 1'b1;

   // Register indexes
   localparam logic REG_ROOT_VERTEX = 1'b0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCALE,
      ST_READ,
      ST_CHECK
   } state_type;

endpackage

`default_nettype wire

// File: rtl/vbd_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module vbd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write on we, register read data on re, hold it otherwise
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: rtl/visited_bitmap_dedup_dispatch.sv
// Top level of the visited-map duplicate filter for graph traversal.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_type, req_vertex
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_out_vertex, rsp_channel
//  csr     | in/out    | APB, pready tied 1   | root_vertex at byte address 0
//
// A vertex transaction passes through accept, word-index wrap, map read, and
// check and write back, using the single read-modify-write port of the map.
// A start transaction clears the map one word a cycle and then marks the root
// vertex. After reset the same clearing pass runs before req_ready rises.
// A result waits in an output register; a stalled rsp holds the filter in its
// check step only when a new result would have to be loaded.
`default_nettype none

module visited_bitmap_dedup_dispatch #(
   parameter int BANK_DEPTH = vbd_pkg::BANK_DEPTH_DEF,
   parameter int BANKS      = vbd_pkg::BANKS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_type,
   input  wire logic [vbd_pkg::VX_W-1:0]    req_vertex,
   // result channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic      [vbd_pkg::VX_W-1:0]    rsp_out_vertex,
   output logic      [vbd_pkg::CH_W-1:0]    rsp_channel,
   // configuration port
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [vbd_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [vbd_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic      [vbd_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                             csr_pready
);

   import vbd_pkg::*;

   localparam int MAP_WORDS = BANKS * BANK_DEPTH;
   localparam int AW        = $clog2(MAP_WORDS);
   localparam int RECIP     = (1 << RSHIFT) / MAP_WORDS;
   localparam int PROD_W    = WIDX_W + RSHIFT;
   localparam int MAP_CW    = RSHIFT + 1;
   localparam int MUL2_W    = WIDX_W + MAP_CW;

   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic                 mark_ff, mark_in;
   logic [VX_W-1:0]      root_ff, root_in;
   logic [VX_W-1:0]      vertex_ff, vertex_in;
   logic [WIDX_W-1:0]    quot_ff, quot_in;
   logic [WIDX_W-1:0]    prod2_ff, prod2_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic                 out_valid_ff, out_valid_in;
   logic [VX_W-1:0]      out_vertex_ff, out_vertex_in;

   logic                 accept;
   logic                 csr_wr;
   logic [VX_W-1:0]      scale_src;
   logic [PROD_W-1:0]    scale_prod;
   logic [WIDX_W-1:0]    rem;
   logic [MAP_CW-1:0]    rem_ext;
   logic [AW-1:0]        addr_calc;
   logic [WORD_W-1:0]    bit_mask;
   logic                 hit;
   logic                 slot_free;
   logic                 out_load;
   logic                 ram_we;
   logic                 ram_re;
   logic [AW-1:0]        ram_addr;
   logic [WORD_W-1:0]    ram_wdata;
   logic [WORD_W-1:0]    ram_rdata;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[CSR_AW-1] == REG_ROOT_VERTEX) ? CSR_DW'(root_ff) : '0;

   always_comb begin
      root_in = root_ff;
      if (csr_wr && csr_paddr[CSR_AW-1] == REG_ROOT_VERTEX) begin
         root_in = csr_pwdata[VX_W-1:0];
      end
   end

   // Handshake helpers
   assign accept    = req_valid && req_ready;
   assign slot_free = !out_valid_ff || rsp_ready;
   assign bit_mask  = WORD_W'(1) << vertex_ff[BIT_W-1:0];
   assign hit       = |(ram_rdata & bit_mask);

   // First wrap step: quotient estimate by reciprocal multiply
   assign scale_src  = (req_type == REQ_START) ? root_ff : req_vertex;
   assign scale_prod = PROD_W'(scale_src[VX_W-1:BIT_W]) * PROD_W'(RECIP);
   assign quot_in    = scale_prod[PROD_W-1:RSHIFT];

   // Second wrap step: quotient times map size
   assign prod2_in = WIDX_W'(MUL2_W'(quot_ff) * MUL2_W'(MAP_WORDS));

   // Remainder with one correction step gives the map address
   assign rem       = vertex_ff[VX_W-1:BIT_W] - prod2_ff;
   assign rem_ext   = MAP_CW'(rem);
   assign addr_calc = (rem_ext >= MAP_CW'(MAP_WORDS)) ?
                      AW'(rem_ext - MAP_CW'(MAP_WORDS)) : AW'(rem);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == AW'(MAP_WORDS - 1)) begin
               state_in = mark_ff ? ST_SCALE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_type == REQ_START) ? ST_CLEAR : ST_SCALE;
            end
         end
         ST_SCALE: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = mark_ff ? ST_IDLE : ST_CHECK;
         end
         ST_CHECK: begin
            if (hit || slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_addr  = addr_ff;
      ram_wdata = ram_rdata | bit_mask;
      out_load  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = clr_cnt_ff;
            ram_wdata = '0;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SCALE: begin
            ram_addr = addr_ff;
         end
         ST_READ: begin
            ram_addr  = addr_calc;
            ram_we    = mark_ff;
            ram_re    = !mark_ff;
            ram_wdata = bit_mask;
         end
         ST_CHECK: begin
            out_load = !hit && slot_free;
            ram_we   = out_load;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Datapath register updates
   always_comb begin
      clr_cnt_in    = clr_cnt_ff;
      mark_in       = mark_ff;
      vertex_in     = vertex_ff;
      addr_in       = addr_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_vertex_in = out_vertex_ff;
      if (state_ff == ST_CLEAR) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
      end
      if (accept) begin
         vertex_in  = scale_src;
         clr_cnt_in = '0;
         mark_in    = (req_type == REQ_START);
      end
      if (state_ff == ST_READ) begin
         addr_in = addr_calc;
         mark_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in  = 1'b1;
         out_vertex_in = vertex_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         mark_ff      <= 1'b0;
         root_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         mark_ff      <= mark_in;
         root_ff      <= root_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      vertex_ff     <= vertex_in;
      addr_ff       <= addr_in;
      out_vertex_ff <= out_vertex_in;
      if (accept) begin
         quot_ff <= quot_in;
      end
      if (state_ff == ST_SCALE) begin
         prod2_ff <= prod2_in;
      end
   end

   // Visited map
   vbd_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_vertex = out_vertex_ff;
   assign rsp_channel    = out_vertex_ff[CH_LO+CH_W-1:CH_LO];

   // Checks
`include "assert_macros.svh"

   `ASSERT_IMPL_NEXT(a_start_clears, clock, reset, accept && (req_type == REQ_START), (state_ff == ST_CLEAR) && (clr_cnt_ff == '0), "start transaction did not begin a clearing pass")
   `ASSERT_IMPL_NOW(a_result_from_check, clock, reset, $rose(out_valid_ff), $past(state_ff) == ST_CHECK, "result appeared outside the check step")
   `ASSERT_IMPL_NOW(a_no_write_on_hit, clock, reset, (state_ff == ST_CHECK) && hit, !ram_we && !out_load, "duplicate vertex was written or passed on")

endmodule

`default_nettype wire
